// ----- design/eecr_pkg.sv -----
`timescale 1ns / 1ps
// eecr_pkg: constants, types and helpers for the EEPROM command responder.
// No dependencies; used by every module of the block.
package eecr_pkg;

	localparam int BLOCKS      = 256;
	localparam int BLOCK_BYTES = 8;
	localparam int BLK_W       = $clog2(BLOCKS);
	localparam int BYTE_W      = $clog2(BLOCK_BYTES);
	localparam int ADDR_W      = BLK_W + BYTE_W;
	localparam int DEPTH       = BLOCKS * BLOCK_BYTES;
	localparam int DATA_W      = 8 * BLOCK_BYTES;
	localparam int IN_W        = 16 + DATA_W;
	localparam int CFG_W       = 16;

	localparam logic [7:0] CMD_PROBE = 8'h00;
	localparam logic [7:0] CMD_RESET = 8'hFF;
	localparam logic [7:0] CMD_READ  = 8'h04;
	localparam logic [7:0] CMD_WRITE = 8'h05;

	localparam logic [7:0] STORE_INIT = 8'h0F;
	localparam logic [7:0] WRITE_ACK  = 8'h00;
	localparam logic [15:0] DEV_ID_RST = 16'hC000;
	localparam logic [7:0] STATUS_RST  = 8'h00;

	localparam logic REG_DEVICE_ID = 1'b0;
	localparam logic REG_STATUS    = 1'b1;

	localparam logic [1:0] PROBE_LAST = 2'd2;
	localparam logic [BYTE_W-1:0] BYTE_LAST = BYTE_W'(BLOCK_BYTES - 1);
	localparam logic [8:0] BLOCKS_V = 9'(BLOCKS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_RD_REQ,
		ST_RD_WAIT,
		ST_WRITE,
		ST_ACK
	} state_t;

	typedef struct packed {
		logic              re;
		logic              we;
		logic              set_vld;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

	// block index modulo BLOCKS; BLOCKS >= 64 so at most four subtractions
	function automatic logic [BLK_W-1:0] blk_wrap(input logic [7:0] b);
		logic [8:0] v;
		v = {1'b0, b};
		for (int i = 0; i < 4; i++) begin
			if (v >= BLOCKS_V) begin
				v = v - BLOCKS_V;
			end
		end
		return v[BLK_W-1:0];
	endfunction

endpackage

// ----- design/eecr_store.sv -----
`timescale 1ns / 1ps
// eecr_store: byte-wide block store with one valid bit per block.
// Depends on eecr_pkg. Unwritten blocks read as the erased pattern.
module eecr_store (
	input  logic              clk,
	input  logic              arst_n,
	input  eecr_pkg::mem_req_t req,
	output logic [7:0]        rdata
);
	import eecr_pkg::*;

	logic [7:0]        mem [DEPTH];
	logic [BLOCKS-1:0] vld_q;
	logic [7:0]        rdata_q;
	logic              rvld_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
			rvld_q  <= vld_q[req.addr[ADDR_W-1:BYTE_W]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.set_vld) begin
			vld_q[req.addr[ADDR_W-1:BYTE_W]] <= 1'b1;
		end
	end

	assign rdata = rvld_q ? rdata_q : STORE_INIT;

endmodule

// ----- design/eecr_seq.sv -----
`timescale 1ns / 1ps
// eecr_seq: command sequencer, config registers and response output register.
// Depends on eecr_pkg; drives the store port one byte per step.
module eecr_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_idx,
	input  logic [eecr_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                in_cmd,
	input  logic [7:0]                in_block,
	input  logic [eecr_pkg::DATA_W-1:0] in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                out_byte,
	output logic                      out_last,
	output eecr_pkg::mem_req_t         req,
	input  logic [7:0]                rdata
);
	import eecr_pkg::*;

	state_t             state_q, state_d;
	logic [15:0]        dev_id_q;
	logic [7:0]         status_q;
	logic [BLK_W-1:0]   blk_q;
	logic [DATA_W-1:0]  data_q;
	logic [BYTE_W-1:0]  cnt_q;
	logic               ovld_q;
	logic [7:0]         obyte_q;
	logic               olast_q;
	logic               accept;
	logic               out_free;
	logic               ld_out;
	logic [7:0]         ld_byte;
	logic               ld_last;
	logic               cnt_inc;
	logic               shift;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !ovld_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_cmd == CMD_PROBE || in_cmd == CMD_RESET) begin
						state_d = ST_PROBE;
					end else if (in_cmd == CMD_READ) begin
						state_d = ST_RD_REQ;
					end else if (in_cmd == CMD_WRITE) begin
						state_d = ST_WRITE;
					end
				end
			end
			ST_PROBE: begin
				if (out_free && cnt_q[1:0] == PROBE_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_RD_REQ: state_d = ST_RD_WAIT;
			ST_RD_WAIT: begin
				if (out_free) begin
					state_d = (cnt_q == BYTE_LAST) ? ST_IDLE : ST_RD_REQ;
				end
			end
			ST_WRITE: begin
				if (cnt_q == BYTE_LAST) begin
					state_d = ST_ACK;
				end
			end
			ST_ACK: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req         = '0;
		req.addr    = {blk_q, cnt_q};
		req.wdata   = data_q[DATA_W-1 -: 8];
		ld_out      = 1'b0;
		ld_byte     = WRITE_ACK;
		ld_last     = 1'b0;
		cnt_inc     = 1'b0;
		shift       = 1'b0;
		unique case (state_q)
			ST_IDLE: ;
			ST_PROBE: begin
				ld_out  = out_free;
				cnt_inc = out_free;
				unique case (cnt_q[1:0])
					2'd0:    ld_byte = dev_id_q[7:0];
					2'd1:    ld_byte = dev_id_q[15:8];
					default: ld_byte = status_q;
				endcase
				ld_last = (cnt_q[1:0] == PROBE_LAST);
			end
			ST_RD_REQ: req.re = 1'b1;
			ST_RD_WAIT: begin
				ld_out  = out_free;
				cnt_inc = out_free;
				ld_byte = rdata;
				ld_last = (cnt_q == BYTE_LAST);
			end
			ST_WRITE: begin
				req.we      = 1'b1;
				req.set_vld = (cnt_q == BYTE_LAST);
				cnt_inc     = 1'b1;
				shift       = 1'b1;
			end
			ST_ACK: begin
				ld_out  = out_free;
				ld_byte = WRITE_ACK;
				ld_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ovld_q   <= 1'b0;
			dev_id_q <= DEV_ID_RST;
			status_q <= STATUS_RST;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (ld_out) begin
				ovld_q <= 1'b1;
			end else if (out_ready) begin
				ovld_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_DEVICE_ID: dev_id_q <= cfg_wdata;
					REG_STATUS:    status_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q  <= blk_wrap(in_block);
			data_q <= in_data;
		end else if (shift) begin
			data_q <= {data_q[DATA_W-9:0], 8'h00};
		end
		if (ld_out) begin
			obyte_q <= ld_byte;
			olast_q <= ld_last;
		end
	end

	assign out_valid = ovld_q;
	assign out_byte  = obyte_q;
	assign out_last  = olast_q;

endmodule

// ----- design/block_eeprom_command_responder.sv -----
`timescale 1ns / 1ps
// block_eeprom_command_responder: top level of the block-addressed EEPROM emulator.
// Depends on eecr_pkg, eecr_seq and eecr_store.
//
//  channel | direction | signals                   | payload
//  s       | in        | s_tvalid s_tready s_tdata | cmd, block, data
//  m       | out       | m_tvalid m_tready m_tdata | resp_byte, last on m_tlast
//  cfg     | in        | cfg_we cfg_idx cfg_wdata  | device_id, status_byte
//
// One command frame at a time; s_tready is high only while idle.
// Probe/reset: 3 response bytes. Read: each byte takes a request state and a wait
// state through the single store port. Write: 8 byte writes plus one ack byte.
// m_tready low holds the sequencer at the next response byte. Reset marks every
// block unwritten (reads as 0x0F) at once; no clearing pass.
module block_eeprom_command_responder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_idx,
	input  logic [eecr_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [eecr_pkg::IN_W-1:0]     s_tdata,   // cmd[7:0], block[15:8], data[79:16]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,   // resp_byte[7:0]
	output logic                         m_tlast
);
	import eecr_pkg::*;

	mem_req_t   req;
	logic [7:0] rdata;

	eecr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tdata[7:0]),
		.in_block  (s_tdata[15:8]),
		.in_data   (s_tdata[IN_W-1:16]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast),
		.req       (req),
		.rdata     (rdata)
	);

	eecr_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	logic s_acc;
	assign s_acc = s_tvalid && s_tready;

	a_busy_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		req.we |-> !s_tready)
		else $error("store write while accepting frames");

	a_write_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tdata[7:0] == CMD_WRITE |=> req.we)
		else $error("write frame did not start store writes");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tdata[7:0] == CMD_READ |=> !s_tready && req.re)
		else $error("read frame did not start store reads");

	a_unknown_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tdata[7:0] != CMD_PROBE && s_tdata[7:0] != CMD_RESET &&
		s_tdata[7:0] != CMD_READ && s_tdata[7:0] != CMD_WRITE |=> s_tready)
		else $error("unknown command left the block busy");

endmodule
